[src/igcd_pkg.sv]
// ----------------------------------------------------------------------------
// igcd_pkg
// Shared constants for the integer gcd block.
// ----------------------------------------------------------------------------
package igcd_pkg;
    localparam int DefDataWidth = 64;
endpackage

[src/igcd_cell.sv]
// ----------------------------------------------------------------------------
// igcd_cell
// One bit slice of the binary gcd datapath. Holds one bit of each value and
// hands its bit to the lower neighbor when the row shifts right.
// ----------------------------------------------------------------------------
module igcd_cell
    import igcd_pkg::*;
(
    input  logic i_clk,
    input  logic i_load,
    input  logic i_a_load,
    input  logic i_b_load,
    input  logic i_a_sel_up,  // take upper neighbor's bit
    input  logic i_b_sel_up,
    input  logic i_a_sel_d,   // take difference bit
    input  logic i_b_sel_d,
    input  logic i_a_up,
    input  logic i_b_up,
    input  logic i_diff,
    output logic o_a,
    output logic o_b
);
    logic r_a, n_a, r_b, n_b;

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        if (i_load) begin
            n_a = i_a_load;
            n_b = i_b_load;
        end else begin
            if (i_a_sel_up) n_a = i_a_up;
            else if (i_a_sel_d) n_a = i_diff;
            if (i_b_sel_up) n_b = i_b_up;
            else if (i_b_sel_d) n_b = i_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
    end

    assign o_a = r_a;
    assign o_b = r_b;
endmodule

[src/integer_gcd.sv]
// ----------------------------------------------------------------------------
// integer_gcd
// Binary (Stein) gcd of two signed integers over a row of bit cells.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata fields (low bit up)
// s_axis    in   operand_a[63:0], operand_b[127:64]
// m_axis    out  divisor[63:0]
// One item at a time. After the load, each step either strips a common or
// single factor of two (shift) or replaces the larger value by the difference.
// Every subtraction leaves an even value, so the next step is a shift. Each
// shift drops at least one of the 2*DATA_WIDTH operand bits. The numbers of
// shift and subtract steps decide how long an item takes.
// Reset is synchronous and clears the control only. The result waits in an
// output register, and the next item is taken once it is transferred.
module integer_gcd
    import igcd_pkg::*;
#(
    parameter int DATA_WIDTH = DefDataWidth
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [127:0]              s_axis_tdata,  // operand_a, operand_b
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [63:0]               m_axis_tdata   // divisor
);
    localparam int KW = $clog2(DATA_WIDTH + 1);
    localparam logic [1:0] S_IDLE = 2'd0, S_RUN = 2'd1, S_OUT = 2'd2;

    logic [1:0] r_state, n_state;
    logic [KW-1:0] r_k, n_k;
    logic [DATA_WIDTH-1:0] a, b, diff, a_in, b_in, va, vb, r_res;
    logic [DATA_WIDTH:0] sub;
    logic load, a_sh, b_sh, both_sh, a_gt, upd_a, upd_b, fin;

    assign va = s_axis_tdata[DATA_WIDTH-1:0];
    assign vb = s_axis_tdata[64 +: DATA_WIDTH];
    assign a_in = va[DATA_WIDTH-1] ? DATA_WIDTH'(-va) : va;
    assign b_in = vb[DATA_WIDTH-1] ? DATA_WIDTH'(-vb) : vb;

    assign s_axis_tready = (r_state == S_IDLE);
    assign load = s_axis_tvalid && s_axis_tready;
    assign sub = {1'b0, a} - {1'b0, b};
    assign a_gt = !sub[DATA_WIDTH];
    assign diff = a_gt ? sub[DATA_WIDTH-1:0] : b - a;

    // Step choice: a zero or two equal values end; even values shift; two odd values subtract.
    always_comb begin
        fin = (r_state == S_RUN) && (a == '0 || b == '0 || a == b);
        both_sh = !fin && !a[0] && !b[0];
        a_sh = !fin && !a[0];
        b_sh = !fin && !b[0];
        upd_a = !fin && a[0] && b[0] && a_gt;
        upd_b = !fin && a[0] && b[0] && !a_gt;
    end

    for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
        igcd_cell u_cell (
            .i_clk(i_clk), .i_load(load),
            .i_a_load(a_in[i]), .i_b_load(b_in[i]),
            .i_a_sel_up((r_state == S_RUN) && a_sh),
            .i_b_sel_up((r_state == S_RUN) && b_sh),
            .i_a_sel_d((r_state == S_RUN) && upd_a),
            .i_b_sel_d((r_state == S_RUN) && upd_b),
            .i_a_up((i == DATA_WIDTH-1) ? 1'b0 : a[(i+1) % DATA_WIDTH]),
            .i_b_up((i == DATA_WIDTH-1) ? 1'b0 : b[(i+1) % DATA_WIDTH]),
            .i_diff(diff[i]),
            .o_a(a[i]), .o_b(b[i])
        );
    end

    always_comb begin
        n_state = r_state;
        n_k = r_k;
        unique case (r_state)
            S_IDLE: if (load) begin
                n_state = S_RUN;
                n_k = '0;
            end
            S_RUN: if (fin) n_state = S_OUT;
                else if (both_sh) n_k = r_k + 1'b1;
            S_OUT: if (m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k <= '0;
        end else begin
            r_state <= n_state;
            r_k <= n_k;
        end
        if (fin) r_res <= (a | b) << r_k;
    end

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata = 64'(r_res);
endmodule
